>>> src/mtde_pkg.sv
// Shared widths, latencies, constant tables and interface types for the
// metal target depth estimator. No dependencies.
package mtde_pkg;

    localparam int CLASS_COUNT = 8;
    localparam int CLS_W       = 3;
    localparam int CLS_IDX_W   = 4;
    localparam int COEF_W      = 5;
    localparam int AMP_W       = 20;
    localparam int MAG_W       = 24;
    localparam int STR_W       = 24;
    localparam int TILT_W      = 16;
    localparam int LIMIT_W     = 16;
    localparam int FLOOR_W     = 17;
    localparam int COS_W       = 17;
    localparam int RAW_W       = 22;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    // ratio divider and square root
    localparam int RATIO_BITS  = 32;
    localparam int ROOT_BITS   = 16;
    localparam int ROOT_REM_W  = ROOT_BITS + 1;
    localparam int ROOT_LAT    = RATIO_BITS + ROOT_BITS + 1;

    // cosine series
    localparam int DIV_STEPS   = 5;
    localparam int Q30_W       = 31;
    localparam int Y_W         = 32;
    localparam int X_W         = 31;
    localparam int STEP_DIV_W  = 7;
    localparam int COS_SUBS    = 3 * DIV_STEPS;
    localparam int COS_LAT     = 2 + COS_SUBS + 1;
    localparam int ALIGN       = ROOT_LAT - COS_LAT;

    localparam logic [Q30_W-1:0] Q30_ONE          = 31'h4000_0000;
    localparam logic [TILT_W-1:0] TILT_RIGHT_ANGLE = 16'd23040;
    localparam logic [16:0]      RAD_PER_UNIT_Q30 = 17'd73204;

    // final divide
    localparam int QUOT_BITS   = RAW_W + 8 - 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMP_REF        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_COS_FLOOR = 2'd2;

    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [COEF_W-1:0] coef;
        logic              sat;
        logic              zero;
    } t_root_in;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic              sat;
        logic              zero;
    } t_root_side;

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             zero;
    } t_root_out;

    function automatic logic [COEF_W-1:0] class_coef(input logic [CLS_IDX_W-1:0] idx);
        logic [COEF_W-1:0] k;
        case (idx)
            4'd0:    k = 5'd15;
            4'd1:    k = 5'd12;
            4'd2:    k = 5'd18;
            4'd3:    k = 5'd16;
            4'd4:    k = 5'd17;
            4'd5:    k = 5'd20;
            4'd6:    k = 5'd22;
            default: k = 5'd25;
        endcase
        return k;
    endfunction

    function automatic logic [STEP_DIV_W-1:0] step_div(input int s);
        logic [STEP_DIV_W-1:0] d;
        case (s)
            0:       d = 7'd90;
            1:       d = 7'd56;
            2:       d = 7'd30;
            3:       d = 7'd12;
            default: d = 7'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] step_recip(input int s);
        logic [31:0] m;
        case (s)
            0:       m = 32'd47721858;
            1:       m = 32'd76695844;
            2:       m = 32'd143165576;
            3:       m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

>>> src/mtde_root.sv
// Pipelined ratio divider, square root and class scaling.
// Depends on mtde_pkg.
module mtde_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  mtde_pkg::t_root_in          i_data,
    input  logic [mtde_pkg::AMP_W-1:0]  i_amp_ref,
    output logic                        o_valid,
    output mtde_pkg::t_root_out         o_data
);
    import mtde_pkg::*;

    localparam int DR = RATIO_BITS + ROOT_BITS;

    logic             r_vld  [0:DR-1];
    t_root_side       r_side [0:DR-1];
    logic [AMP_W-1:0]      r_drem [0:RATIO_BITS-1];
    logic [RATIO_BITS-1:0] r_dq   [0:RATIO_BITS-1];
    logic [ROOT_REM_W-1:0] r_srem [0:ROOT_BITS-1];
    logic [ROOT_BITS-1:0]  r_sroot[0:ROOT_BITS-1];
    logic [RATIO_BITS-1:0] r_sq   [0:ROOT_BITS-1];
    logic                  r_out_v;
    t_root_out             r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DR; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DR; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= '{coef: i_data.coef, sat: i_data.sat, zero: i_data.zero};
        for (int k = 1; k < DR; k++) r_side[k] <= r_side[k-1];
    end

    // restoring divide: one quotient bit per stage, low dividend bits are zero
    for (genvar k = 0; k < RATIO_BITS; k++) begin : g_div
        logic [AMP_W-1:0]      w_rem_prev;
        logic [RATIO_BITS-1:0] w_q_prev;
        logic [AMP_W:0]        w_sh;
        logic [AMP_W:0]        w_diff;
        logic                  w_ge;
        if (k == 0) begin : g_first
            assign w_rem_prev = i_data.mag[AMP_W-1:0];
            assign w_q_prev   = '0;
        end else begin : g_next
            assign w_rem_prev = r_drem[k-1];
            assign w_q_prev   = r_dq[k-1];
        end
        assign w_sh   = {w_rem_prev, 1'b0};
        assign w_ge   = w_sh >= {1'b0, i_amp_ref};
        assign w_diff = w_sh - {1'b0, i_amp_ref};
        always_ff @(posedge i_clk) begin
            r_drem[k] <= w_ge ? w_diff[AMP_W-1:0] : w_sh[AMP_W-1:0];
            r_dq[k]   <= {w_q_prev[RATIO_BITS-2:0], w_ge};
        end
    end

    // digit-by-digit square root, one root bit per stage
    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
        logic [ROOT_REM_W-1:0] w_rem_prev;
        logic [ROOT_BITS-1:0]  w_root_prev;
        logic [RATIO_BITS-1:0] w_q_prev;
        logic [ROOT_REM_W+1:0] w_sh;
        logic [ROOT_REM_W+1:0] w_trial;
        logic [ROOT_REM_W+1:0] w_diff;
        logic                  w_ge;
        if (j == 0) begin : g_first
            assign w_rem_prev  = '0;
            assign w_root_prev = '0;
            assign w_q_prev    = r_dq[RATIO_BITS-1];
        end else begin : g_next
            assign w_rem_prev  = r_srem[j-1];
            assign w_root_prev = r_sroot[j-1];
            assign w_q_prev    = r_sq[j-1];
        end
        assign w_sh    = {w_rem_prev, w_q_prev[RATIO_BITS-1 -: 2]};
        assign w_trial = {1'b0, w_root_prev, 2'b01};
        assign w_ge    = w_sh >= w_trial;
        assign w_diff  = w_sh - w_trial;
        always_ff @(posedge i_clk) begin
            r_srem[j]  <= w_ge ? w_diff[ROOT_REM_W-1:0] : w_sh[ROOT_REM_W-1:0];
            r_sroot[j] <= {w_root_prev[ROOT_BITS-2:0], w_ge};
            r_sq[j]    <= {w_q_prev[RATIO_BITS-3:0], 2'b00};
        end
    end

    logic [ROOT_BITS:0]  w_root;
    logic [RAW_W-1:0]    w_raw;
    t_root_side          w_side;

    assign w_side = r_side[DR-1];
    assign w_root = w_side.sat ? {1'b1, {ROOT_BITS{1'b0}}} : {1'b0, r_sroot[ROOT_BITS-1]};
    assign w_raw  = RAW_W'(w_side.coef) * RAW_W'(w_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_vld[DR-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= '{raw: w_raw, zero: w_side.zero};
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

>>> src/mtde_cos.sv
// Pipelined fixed-point cosine series of the tilt with the floor applied.
// Depends on mtde_pkg.
module mtde_cos (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mtde_pkg::TILT_W-1:0]   i_tilt_mag,
    input  logic [mtde_pkg::FLOOR_W-1:0]  i_cos_floor,
    output logic                          o_valid,
    output logic [mtde_pkg::COS_W-1:0]    o_cos
);
    import mtde_pkg::*;

    logic             r_v1;
    logic             r_big1;
    logic [X_W-1:0]   r_x;
    logic             r_vl [0:COS_SUBS];
    logic             r_bg [0:COS_SUBS];
    logic [Y_W-1:0]   r_yl [0:COS_SUBS-3];
    logic [31:0]      r_n  [0:DIV_STEPS-1];
    logic [31:0]      r_nb [0:DIV_STEPS-1];
    logic [31:0]      r_q0 [0:DIV_STEPS-1];
    logic [Q30_W-1:0] r_t  [0:DIV_STEPS-1];
    logic             r_out_v;
    logic [COS_W-1:0] r_cos;

    logic [32:0]      w_x;
    logic [61:0]      w_xx;

    assign w_x  = 33'(i_tilt_mag) * 33'(RAD_PER_UNIT_Q30);
    assign w_xx = 62'(r_x) * 62'(r_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int k = 0; k <= COS_SUBS; k++) r_vl[k] <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_vl[0] <= r_v1;
            for (int k = 1; k <= COS_SUBS; k++) r_vl[k] <= r_vl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= w_x[X_W-1:0];
        r_big1  <= i_tilt_mag >= TILT_RIGHT_ANGLE;
        r_yl[0] <= w_xx[61:30];
        r_bg[0] <= r_big1;
        for (int k = 1; k <= COS_SUBS; k++) r_bg[k] <= r_bg[k-1];
        for (int k = 1; k <= COS_SUBS-3; k++) r_yl[k] <= r_yl[k-1];
    end

    // each term: multiply by y, divide by a small constant, subtract from one
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam logic [STEP_DIV_W-1:0] D = step_div(s);
        localparam logic [31:0]           M = step_recip(s);
        logic [Q30_W-1:0] w_t_prev;
        logic [62:0]      w_yt;
        logic [63:0]      w_nm;
        logic [38:0]      w_qd;
        logic [38:0]      w_r;
        logic [32:0]      w_p;
        if (s == 0) begin : g_first
            assign w_t_prev = Q30_ONE;
        end else begin : g_next
            assign w_t_prev = r_t[s-1];
        end
        assign w_yt = 63'(r_yl[3*s]) * 63'(w_t_prev);
        assign w_nm = 64'(r_n[s]) * 64'(M);
        assign w_qd = 39'(r_q0[s]) * 39'(D);
        assign w_r  = 39'(r_nb[s]) - w_qd;
        assign w_p  = 33'(r_q0[s]) + 33'(w_r >= 39'(D));
        always_ff @(posedge i_clk) begin
            r_n[s]  <= w_yt[61:30];
            r_q0[s] <= w_nm[63:32];
            r_nb[s] <= r_n[s];
            r_t[s]  <= (w_p > 33'(Q30_ONE)) ? '0 : Q30_W'(33'(Q30_ONE) - w_p);
        end
    end

    logic [COS_W-1:0] w_cos;
    logic [COS_W-1:0] w_c;

    always_comb begin
        w_cos = r_bg[COS_SUBS] ? '0 : r_t[DIV_STEPS-1][Q30_W-1:14];
        w_c   = (w_cos < i_cos_floor) ? i_cos_floor : w_cos;
        if (w_c == '0) begin
            w_c = COS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_vl[COS_SUBS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= w_c;
    end

    assign o_valid = r_out_v;
    assign o_cos   = r_cos;

endmodule

>>> src/metal_target_depth_estimator.sv
// Path from the start transfer to the result strobe: input register, 32-step ratio
// divider, 16-step square root, scale, 29-step depth divider, clamp.
// Throughput: one item per cycle; busy stays low, the pipeline never holds off.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// The receiver cannot stall, so the result strobe lasts exactly one cycle.
// Depends on mtde_pkg, mtde_root and mtde_cos.
module metal_target_depth_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [mtde_pkg::STR_W-1:0] i_signal_strength,
    input  logic [mtde_pkg::CLS_W-1:0]        i_target_class,
    input  logic signed [mtde_pkg::TILT_W-1:0] i_tilt_angle,
    output logic                              o_strobe,
    output logic [mtde_pkg::LIMIT_W-1:0]      o_depth,
    output logic                              o_depth_clamped,
    input  logic                              i_cfg_we,
    input  logic [mtde_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mtde_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mtde_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers; the user writes them only while the pipe is empty, not enforced here
    // ---------------------------------------------------------------
    logic [AMP_W-1:0]   r_amp_ref;
    logic [LIMIT_W-1:0] r_depth_limit;
    logic [FLOOR_W-1:0] r_cos_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_ref     <= AMP_W'(32768);
            r_depth_limit <= LIMIT_W'(20480);
            r_cos_floor   <= FLOOR_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AMP_REF:        r_amp_ref     <= i_cfg_data[AMP_W-1:0];
                REG_DEPTH_LIMIT:    r_depth_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_TILT_COS_FLOOR: r_cos_floor   <= FLOOR_W'(i_cfg_data);
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // The pipeline takes a transfer in every cycle.
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // ---------------------------------------------------------------
    // Input stage: magnitudes, class coefficient, saturation of the ratio
    // ---------------------------------------------------------------
    logic [MAG_W-1:0]     w_mag;
    logic [TILT_W-1:0]    w_tilt_mag;
    logic [CLS_IDX_W-1:0] w_cls;
    logic [CLS_IDX_W-1:0] w_cls_idx;

    assign w_mag      = i_signal_strength[STR_W-1] ? (~i_signal_strength + 1'b1)
                                                   : i_signal_strength;
    assign w_tilt_mag = i_tilt_angle[TILT_W-1] ? (~i_tilt_angle + 1'b1) : i_tilt_angle;
    assign w_cls      = CLS_IDX_W'(i_target_class);
    // classes past the table fold onto the last one
    assign w_cls_idx  = (w_cls >= CLS_IDX_W'(CLASS_COUNT)) ? CLS_IDX_W'(CLASS_COUNT - 1)
                                                          : w_cls;

    logic             r_s0_v;
    t_root_in         r_s0;
    logic [TILT_W-1:0] r_s0_tilt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0.mag  <= w_mag;
        r_s0.coef <= class_coef(w_cls_idx);
        // a zero reference saturates the ratio to one
        r_s0.sat  <= (r_amp_ref == '0) || (w_mag >= MAG_W'(r_amp_ref));
        r_s0.zero <= (w_mag == '0);
        r_s0_tilt <= w_tilt_mag;
    end

    // ---------------------------------------------------------------
    // Parallel branches: amplitude root and tilt cosine
    // ---------------------------------------------------------------
    logic             w_root_v;
    t_root_out        w_root;
    logic             w_cos_v;
    logic [COS_W-1:0] w_cos;

    mtde_root u_root (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s0_v),
        .i_data    (r_s0),
        .i_amp_ref (r_amp_ref),
        .o_valid   (w_root_v),
        .o_data    (w_root)
    );

    mtde_cos u_cos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s0_v),
        .i_tilt_mag  (r_s0_tilt),
        .i_cos_floor (r_cos_floor),
        .o_valid     (w_cos_v),
        .o_cos       (w_cos)
    );

    // Delay the cosine so it meets the root branch; its valid bit rides along.
    logic [COS_W-1:0] r_cd  [0:ALIGN-1];
    logic             r_cdv [0:ALIGN-1];

    always_ff @(posedge i_clk) begin
        r_cd[0] <= w_cos;
        for (int k = 1; k < ALIGN; k++) r_cd[k] <= r_cd[k-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ALIGN; k++) r_cdv[k] <= 1'b0;
        end else begin
            r_cdv[0] <= w_cos_v;
            for (int k = 1; k < ALIGN; k++) r_cdv[k] <= r_cdv[k-1];
        end
    end

    logic [COS_W-1:0] w_c_al;
    assign w_c_al = r_cd[ALIGN-1];

    // ---------------------------------------------------------------
    // Depth divider: (raw << 8) / c, one quotient bit per stage.
    // The quotient register doubles as the dividend shifter.
    // ---------------------------------------------------------------
    logic                 r_qv   [0:QUOT_BITS-1];
    logic                 r_qz   [0:QUOT_BITS-1];
    logic [COS_W-1:0]     r_qc   [0:QUOT_BITS-1];
    logic [COS_W-1:0]     r_qrem [0:QUOT_BITS-1];
    logic [QUOT_BITS-1:0] r_qq   [0:QUOT_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUOT_BITS; k++) r_qv[k] <= 1'b0;
        end else begin
            r_qv[0] <= w_root_v;
            for (int k = 1; k < QUOT_BITS; k++) r_qv[k] <= r_qv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_qz[0] <= w_root.zero;
        r_qc[0] <= w_c_al;
        for (int k = 1; k < QUOT_BITS; k++) begin
            r_qz[k] <= r_qz[k-1];
            r_qc[k] <= r_qc[k-1];
        end
    end

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_qdiv
        logic [COS_W-1:0]     w_rem_prev;
        logic [QUOT_BITS-1:0] w_q_prev;
        logic [COS_W-1:0]     w_c;
        logic [COS_W:0]       w_sh;
        logic [COS_W:0]       w_diff;
        logic                 w_ge;
        if (k == 0) begin : g_first
            // raw never reaches its top bit, so raw << 8 fits the quotient width
            assign w_rem_prev = '0;
            assign w_q_prev   = {w_root.raw[RAW_W-2:0], 8'd0};
            assign w_c        = w_c_al;
        end else begin : g_next
            assign w_rem_prev = r_qrem[k-1];
            assign w_q_prev   = r_qq[k-1];
            assign w_c        = r_qc[k-1];
        end
        assign w_sh   = {w_rem_prev, w_q_prev[QUOT_BITS-1]};
        assign w_ge   = w_sh >= {1'b0, w_c};
        assign w_diff = w_sh - {1'b0, w_c};
        always_ff @(posedge i_clk) begin
            r_qrem[k] <= w_ge ? w_diff[COS_W-1:0] : w_sh[COS_W-1:0];
            r_qq[k]   <= {w_q_prev[QUOT_BITS-2:0], w_ge};
        end
    end

    // ---------------------------------------------------------------
    // Clamp and output register
    // ---------------------------------------------------------------
    logic [QUOT_BITS-1:0] w_q;
    logic [LIMIT_W-1:0]   n_depth;
    logic                 n_clamped;

    assign w_q = r_qq[QUOT_BITS-1];

    always_comb begin
        if (r_qz[QUOT_BITS-1]) begin
            n_depth   = '0;
            n_clamped = 1'b0;
        end else if (w_q > QUOT_BITS'(r_depth_limit)) begin
            n_depth   = r_depth_limit;
            n_clamped = 1'b1;
        end else begin
            n_depth   = w_q[LIMIT_W-1:0];
            n_clamped = 1'b0;
        end
    end

    logic               r_strobe;
    logic [LIMIT_W-1:0] r_depth;
    logic               r_depth_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_qv[QUOT_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_depth         <= n_depth;
        r_depth_clamped <= n_clamped;
    end

    assign o_strobe        = r_strobe;
    assign o_depth         = r_depth;
    assign o_depth_clamped = r_depth_clamped;

`ifndef NO_ASSERTIONS
    a_clamp_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_depth_clamped |-> r_depth == r_depth_limit)
        else $error("clamped result differs from depth limit");

    a_within_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_depth_clamped |-> r_depth <= r_depth_limit)
        else $error("unclamped result exceeds depth limit");

    a_branch_align : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_v == r_cdv[ALIGN-1])
        else $error("root and cosine branches out of step");

    a_divisor_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_v |-> w_c_al != '0)
        else $error("zero divisor reached depth divider");
`endif

endmodule
